### rtl/tbgd_pkg.sv
// ----------------------------------------------------------------------------
// Two-button gesture detector package
// Shared types, codes and helpers for the gesture detector block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbgd_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int COUNT_W     = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GESTURE_WINDOW = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_WINDOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_CHECK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_HEAD      = 3'd4;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_GESTURE_WINDOW = 8'd6;
    localparam logic [CFG_DATA_W-1:0] RST_REPEAT_WINDOW  = 8'd1;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_CHECK     = 8'd1;
    localparam logic [CFG_DATA_W-1:0] RST_LONG_THRESHOLD = 8'd20;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_HEAD      = 8'd10;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PRESS = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WIN  = 2'd1,
        PH_REP  = 2'd2,
        PH_HOLD = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        G_NONE    = 3'd0,
        G_SINGLE1 = 3'd1,
        G_SINGLE2 = 3'd2,
        G_DOUBLE1 = 3'd3,
        G_DOUBLE2 = 3'd4,
        G_BOTH    = 3'd5,
        G_LONG1   = 3'd6,
        G_LONG2   = 3'd7
    } gesture_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       button_one_level;
        logic       button_two_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0] gesture;
        logic       gesture_pending;
        logic [1:0] timer_phase;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] gesture_window_ticks;
        logic [CFG_DATA_W-1:0] repeat_window_ticks;
        logic [CFG_DATA_W-1:0] hold_check_ticks;
        logic [CFG_DATA_W-1:0] long_hold_level;
        logic [CFG_DATA_W-1:0] hold_head_start;
    } cfg_t;

    typedef struct packed {
        gesture_t           held_gesture;
        logic               pending;
        phase_t             phase;
        logic [COUNT_W-1:0] count_one;
        logic [COUNT_W-1:0] count_two;
        logic [COUNT_W-1:0] tick_count;
    } state_t;

    // Saturating 8-bit add
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

### rtl/tbgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Gesture detector configuration registers
// Holds the five timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbgd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tbgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbgd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tbgd_pkg::cfg_t                   cfg
);

    tbgd_pkg::cfg_t cfg_reg;
    tbgd_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes drop the data
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tbgd_pkg::REG_GESTURE_WINDOW: cfg_next.gesture_window_ticks = cfg_wdata;
                tbgd_pkg::REG_REPEAT_WINDOW:  cfg_next.repeat_window_ticks  = cfg_wdata;
                tbgd_pkg::REG_HOLD_CHECK:     cfg_next.hold_check_ticks     = cfg_wdata;
                tbgd_pkg::REG_LONG_THRESHOLD: cfg_next.long_hold_level      = cfg_wdata;
                tbgd_pkg::REG_HOLD_HEAD:      cfg_next.hold_head_start      = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gesture_window_ticks <= tbgd_pkg::RST_GESTURE_WINDOW;
            cfg_reg.repeat_window_ticks  <= tbgd_pkg::RST_REPEAT_WINDOW;
            cfg_reg.hold_check_ticks     <= tbgd_pkg::RST_HOLD_CHECK;
            cfg_reg.long_hold_level      <= tbgd_pkg::RST_LONG_THRESHOLD;
            cfg_reg.hold_head_start      <= tbgd_pkg::RST_HOLD_HEAD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tbgd_in_stage.sv
// ----------------------------------------------------------------------------
// Gesture detector input stage
// Registers one accepted item and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbgd_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tbgd_pkg::in_item_t s_data,
    input  logic               consume,
    output logic               item_valid,
    output tbgd_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    tbgd_pkg::in_item_t data_reg;

    // Take a new item when empty or when the held one leaves this cycle
    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

### rtl/tbgd_engine.sv
// ----------------------------------------------------------------------------
// Gesture detector engine
// Holds the detector state and computes one item's update and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbgd_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  tbgd_pkg::in_item_t  item,
    input  tbgd_pkg::cfg_t      cfg,
    output tbgd_pkg::out_item_t result
);

    tbgd_pkg::state_t   state_reg;
    tbgd_pkg::state_t   state_next;
    tbgd_pkg::state_t   exp_state;
    tbgd_pkg::state_t   hold_state;
    tbgd_pkg::gesture_t exp_gesture;
    tbgd_pkg::gesture_t read_gesture;
    logic               exp_flag;
    logic               low1;
    logic               low2;
    logic [tbgd_pkg::COUNT_W-1:0] tick_inc;
    logic [tbgd_pkg::COUNT_W-1:0] limit;
    logic [tbgd_pkg::COUNT_W:0]   count_sum;
    logic                         qual1;
    logic                         qual2;

    assign low1     = !item.button_one_level;
    assign low2     = !item.button_two_level;
    assign tick_inc = tbgd_pkg::sat_add(state_reg.tick_count, 8'd1);

    // Pick the wait of the current phase
    always_comb begin
        case (state_reg.phase)
            tbgd_pkg::PH_WIN: limit = cfg.gesture_window_ticks;
            tbgd_pkg::PH_REP: limit = cfg.repeat_window_ticks;
            default:          limit = cfg.hold_check_ticks;
        endcase
    end

    // Classify at window expiry
    always_comb begin
        exp_state            = state_reg;
        exp_state.tick_count = tick_inc;
        exp_state.phase      = tbgd_pkg::PH_IDLE;
        exp_gesture          = tbgd_pkg::G_NONE;
        exp_flag             = 1'b1;
        count_sum = {1'b0, state_reg.count_one} + {1'b0, state_reg.count_two};
        if (count_sum == 9'd0) begin
            exp_flag = 1'b0;
        end else if (count_sum == 9'd1) begin
            if (low1 || low2) begin
                // lone press still held: start hold checking with a head start
                if (low1) begin
                    exp_state.count_one = tbgd_pkg::sat_add(state_reg.count_one,
                                                            cfg.hold_head_start);
                end
                if (low2) begin
                    exp_state.count_two = tbgd_pkg::sat_add(state_reg.count_two,
                                                            cfg.hold_head_start);
                end
                exp_flag             = 1'b0;
                exp_state.tick_count = '0;
                exp_state.phase      = tbgd_pkg::PH_HOLD;
            end else begin
                exp_gesture = (state_reg.count_two != '0) ? tbgd_pkg::G_SINGLE2
                                                          : tbgd_pkg::G_SINGLE1;
            end
        end else if (count_sum == 9'd2) begin
            if (state_reg.count_two == 8'd2) begin
                exp_gesture = tbgd_pkg::G_DOUBLE2;
            end else if (state_reg.count_one == 8'd2) begin
                exp_gesture = tbgd_pkg::G_DOUBLE1;
            end
        end else if (count_sum == 9'd3) begin
            if (state_reg.count_one == 8'd3 && state_reg.count_two == '0) begin
                exp_gesture = tbgd_pkg::G_DOUBLE1;
            end else if (state_reg.count_two == 8'd3 && state_reg.count_one == '0) begin
                exp_gesture = tbgd_pkg::G_DOUBLE2;
            end else if (state_reg.count_one != '0 && state_reg.count_two != '0) begin
                exp_gesture = tbgd_pkg::G_BOTH;
            end
        end else begin
            if (state_reg.count_one != '0 && state_reg.count_two != '0) begin
                exp_gesture = tbgd_pkg::G_BOTH;
            end else if (state_reg.count_one >= 8'd2) begin
                exp_gesture = tbgd_pkg::G_DOUBLE1;
            end else if (state_reg.count_two >= 8'd2) begin
                exp_gesture = tbgd_pkg::G_DOUBLE2;
            end
        end
        exp_state.held_gesture = exp_gesture;
        exp_state.pending      = exp_flag;
        if (exp_state.phase != tbgd_pkg::PH_HOLD) begin
            exp_state.count_one = '0;
            exp_state.count_two = '0;
        end
    end

    // Hold check: report a long press, keep counting or drop back to idle
    assign qual1 = state_reg.count_one >= cfg.long_hold_level;
    assign qual2 = state_reg.count_two >= cfg.long_hold_level;

    always_comb begin
        hold_state            = state_reg;
        hold_state.tick_count = tick_inc;
        if (qual1 || qual2) begin
            hold_state.held_gesture = qual2 ? tbgd_pkg::G_LONG2 : tbgd_pkg::G_LONG1;
            hold_state.pending      = 1'b1;
            hold_state.count_one    = '0;
            hold_state.count_two    = '0;
            hold_state.phase        = tbgd_pkg::PH_IDLE;
        end else if (low1 || low2) begin
            if (low1) begin
                hold_state.count_one = tbgd_pkg::sat_add(state_reg.count_one, 8'd1);
            end
            if (low2) begin
                hold_state.count_two = tbgd_pkg::sat_add(state_reg.count_two, 8'd1);
            end
            hold_state.tick_count = '0;
            hold_state.phase      = tbgd_pkg::PH_HOLD;
        end else begin
            hold_state.count_one = '0;
            hold_state.count_two = '0;
            hold_state.phase     = tbgd_pkg::PH_IDLE;
        end
    end

    // Apply the command of the item
    always_comb begin
        state_next   = state_reg;
        read_gesture = tbgd_pkg::G_NONE;
        case (item.cmd)
            tbgd_pkg::CMD_TICK: begin
                if (state_reg.phase != tbgd_pkg::PH_IDLE) begin
                    state_next.tick_count = tick_inc;
                    if (tick_inc >= limit) begin
                        state_next = (state_reg.phase == tbgd_pkg::PH_HOLD) ? hold_state
                                                                           : exp_state;
                    end
                end
            end
            tbgd_pkg::CMD_PRESS: begin
                if (low1 && low2) begin
                    state_next.held_gesture = tbgd_pkg::G_BOTH;
                    state_next.pending      = 1'b1;
                    state_next.count_one    = '0;
                    state_next.count_two    = '0;
                    state_next.phase        = tbgd_pkg::PH_IDLE;
                end else begin
                    if (low1) begin
                        state_next.count_one = tbgd_pkg::sat_add(state_reg.count_one, 8'd1);
                    end
                    if (low2) begin
                        state_next.count_two = tbgd_pkg::sat_add(state_reg.count_two, 8'd1);
                    end
                    state_next.tick_count = '0;
                    state_next.phase = (state_reg.phase == tbgd_pkg::PH_WIN ||
                                        state_reg.phase == tbgd_pkg::PH_REP)
                                       ? tbgd_pkg::PH_REP : tbgd_pkg::PH_WIN;
                end
            end
            tbgd_pkg::CMD_READ: begin
                if (state_reg.pending) begin
                    read_gesture            = state_reg.held_gesture;
                    state_next.pending      = 1'b0;
                    state_next.held_gesture = tbgd_pkg::G_NONE;
                end
            end
            default: ;
        endcase
    end

    // Advance the state only when an item passes through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.held_gesture <= tbgd_pkg::G_NONE;
            state_reg.pending      <= 1'b0;
            state_reg.phase        <= tbgd_pkg::PH_IDLE;
            state_reg.count_one    <= '0;
            state_reg.count_two    <= '0;
            state_reg.tick_count   <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign result.gesture         = read_gesture;
    assign result.gesture_pending = state_next.pending;
    assign result.timer_phase     = state_next.phase;

    // Counts are always cleared whenever the detector is idle
    a_idle_counts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == tbgd_pkg::PH_IDLE |->
            state_reg.count_one == '0 && state_reg.count_two == '0)
        else $error("counts nonzero while idle");

    // State moves only when an item is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("state changed without an item");

    // A read always leaves nothing pending
    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.cmd == tbgd_pkg::CMD_READ |=> !state_reg.pending)
        else $error("pending flag survived a read");

    // A read with nothing pending reports no gesture
    a_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.cmd == tbgd_pkg::CMD_READ && !state_reg.pending |->
            result.gesture == tbgd_pkg::G_NONE)
        else $error("gesture reported with nothing pending");

    // Both buttons pressed at once reports the both gesture
    a_both_press: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.cmd == tbgd_pkg::CMD_PRESS && low1 && low2 |=>
            state_reg.pending && state_reg.held_gesture == tbgd_pkg::G_BOTH &&
            state_reg.phase == tbgd_pkg::PH_IDLE)
        else $error("two-button press not reported");

endmodule

### rtl/two_button_gesture_detector_unit.sv
// ----------------------------------------------------------------------------
// Two-button gesture detector
// Classifies button events into single, double, both and long gestures.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item per command: timer tick, press
//   event or read-and-clear, together with both pin levels (low = pressed).
//   m_valid/m_ready/m_data return exactly one result per item: the gesture
//   read (zero for other commands), the pending flag and the timer phase.
//   An accepted item first waits in the input register; then the engine
//   updates its state and loads the output register, which raises m_valid.
//   Throughput is one item per cycle while the receiver takes results; the
//   engine's compare and add logic lies between the two registers.
//   When the receiver stalls, the result waits in the output register and
//   the input register still takes one more item; s_ready falls once both
//   are full. The cfg_* port writes the timing registers; the user must
//   use it only while the block is idle, which the block does not enforce.
//   Reset (aresetn low, synchronous) empties both registers, clears all
//   detector state and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_button_gesture_detector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tbgd_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tbgd_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [tbgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbgd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    tbgd_pkg::cfg_t      cfg;
    tbgd_pkg::in_item_t  item;
    tbgd_pkg::out_item_t result;
    logic                item_valid;
    logic                advance;
    logic                m_valid_reg;
    logic                m_valid_next;
    tbgd_pkg::out_item_t m_data_reg;

    tbgd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbgd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .consume    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tbgd_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    // Move an item to the output when the output slot is free or draining
    assign advance      = item_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = advance || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result; hold it while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### bench/tb_two_button_gesture_detector_unit.sv
// ----------------------------------------------------------------------------
// Two-button gesture detector testbench
// Drives timer ticks, press events and reads through the valid/ready input
// channel and predicts every result in a scoreboard that models the detector
// state. Checks run for each result: gesture, pending flag and timer phase.
// The run moves through several timing register settings, from zero and
// minimum to maximum. Random gaps and stalls fall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_button_gesture_detector_unit;

    import tbgd_pkg::*;

    // Command code that the block does not use
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Number of implemented timing registers; higher indexes are unmapped
    localparam int NUM_REGS = 5;
    localparam logic [CFG_INDEX_W-1:0] LAST_INDEX = {CFG_INDEX_W{1'b1}};

    // ------------------------------------------------------------------------
    // Gesture scoreboard: mirrors the detector and checks each result
    // ------------------------------------------------------------------------
    class gesture_scoreboard;
        logic [7:0] win_ticks;
        logic [7:0] rep_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] long_level;
        logic [7:0] head_start;

        gesture_t   held;
        logic       pending;
        phase_t     phase;
        logic [7:0] cnt1;
        logic [7:0] cnt2;
        logic [7:0] ticks;

        out_item_t  predicted_outcomes[$];
        int         errors;

        function new();
            win_ticks  = RST_GESTURE_WINDOW;
            rep_ticks  = RST_REPEAT_WINDOW;
            hold_ticks = RST_HOLD_CHECK;
            long_level = RST_LONG_THRESHOLD;
            head_start = RST_HOLD_HEAD;
            held       = G_NONE;
            pending    = 1'b0;
            phase      = PH_IDLE;
            cnt1       = '0;
            cnt2       = '0;
            ticks      = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
            case (idx)
                REG_GESTURE_WINDOW: win_ticks  = val;
                REG_REPEAT_WINDOW:  rep_ticks  = val;
                REG_HOLD_CHECK:     hold_ticks = val;
                REG_LONG_THRESHOLD: long_level = val;
                REG_HOLD_HEAD:      head_start = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] add_sat(logic [7:0] a, logic [7:0] b);
            int s;
            s = int'(a) + int'(b);
            return (s > 255) ? 8'hFF : 8'(s);
        endfunction

        // Classify the presses counted in the window that just ran out
        function void close_window(bit low1, bit low2);
            int       sum;
            gesture_t g;
            bit       flag;
            sum   = int'(cnt1) + int'(cnt2);
            g     = G_NONE;
            flag  = 1'b1;
            phase = PH_IDLE;
            if (sum == 0) begin
                flag = 1'b0;
            end else if (sum == 1) begin
                if (low1 || low2) begin
                    // lone press still held: enter hold checking
                    if (low1) cnt1 = add_sat(cnt1, head_start);
                    if (low2) cnt2 = add_sat(cnt2, head_start);
                    flag  = 1'b0;
                    ticks = '0;
                    phase = PH_HOLD;
                end else begin
                    g = (cnt2 >= 1) ? G_SINGLE2 : G_SINGLE1;
                end
            end else if (sum == 2) begin
                if (cnt2 == 2) g = G_DOUBLE2;
                else if (cnt1 == 2) g = G_DOUBLE1;
            end else if (sum == 3) begin
                if (cnt1 == 3 && cnt2 == 0) g = G_DOUBLE1;
                else if (cnt2 == 3 && cnt1 == 0) g = G_DOUBLE2;
                else if (cnt1 > 0 && cnt2 > 0) g = G_BOTH;
            end else begin
                if (cnt1 > 0 && cnt2 > 0) g = G_BOTH;
                else if (cnt1 >= 2) g = G_DOUBLE1;
                else if (cnt2 >= 2) g = G_DOUBLE2;
            end
            held    = g;
            pending = flag;
            if (phase != PH_HOLD) begin
                cnt1 = '0;
                cnt2 = '0;
            end
        endfunction

        // One hold check: report a long press, keep counting, or give up
        function void check_hold(bit low1, bit low2);
            bit l1;
            bit l2;
            l1 = (cnt1 >= long_level);
            l2 = (cnt2 >= long_level);
            if (l1 || l2) begin
                held    = l2 ? G_LONG2 : G_LONG1;
                pending = 1'b1;
                cnt1    = '0;
                cnt2    = '0;
                phase   = PH_IDLE;
            end else if (low1 || low2) begin
                if (low1) cnt1 = add_sat(cnt1, 8'd1);
                if (low2) cnt2 = add_sat(cnt2, 8'd1);
                ticks = '0;
                phase = PH_HOLD;
            end else begin
                cnt1  = '0;
                cnt2  = '0;
                phase = PH_IDLE;
            end
        endfunction

        // Advance the mirrored state by one accepted item, queue its result
        function void note_accepted_item(in_item_t it);
            bit        low1;
            bit        low2;
            gesture_t  read_g;
            out_item_t want;
            low1   = (it.button_one_level == 1'b0);
            low2   = (it.button_two_level == 1'b0);
            read_g = G_NONE;
            if (it.cmd == CMD_TICK) begin
                if (phase != PH_IDLE) begin
                    ticks = add_sat(ticks, 8'd1);
                    case (phase)
                        PH_WIN:  if (ticks >= win_ticks) close_window(low1, low2);
                        PH_REP:  if (ticks >= rep_ticks) close_window(low1, low2);
                        default: if (ticks >= hold_ticks) check_hold(low1, low2);
                    endcase
                end
            end else if (it.cmd == CMD_PRESS) begin
                if (low1) cnt1 = add_sat(cnt1, 8'd1);
                if (low2) cnt2 = add_sat(cnt2, 8'd1);
                if (low1 && low2) begin
                    held    = G_BOTH;
                    pending = 1'b1;
                    cnt1    = '0;
                    cnt2    = '0;
                    phase   = PH_IDLE;
                end else begin
                    ticks = '0;
                    if (phase == PH_WIN || phase == PH_REP) phase = PH_REP;
                    else phase = PH_WIN;
                end
            end else if (it.cmd == CMD_READ) begin
                if (pending) begin
                    read_g  = held;
                    pending = 1'b0;
                    held    = G_NONE;
                end
            end
            want.gesture         = read_g;
            want.gesture_pending = pending;
            want.timer_phase     = phase;
            predicted_outcomes.push_back(want);
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t want;
            if (predicted_outcomes.size() == 0) begin
                $error("unexpected result: gesture %0d, pending %0d, phase %0d",
                       got.gesture, got.gesture_pending, got.timer_phase);
                errors++;
                return;
            end
            want = predicted_outcomes.pop_front();
            if (got.gesture !== want.gesture) begin
                $error("gesture: expected %0d, actual %0d", want.gesture, got.gesture);
                errors++;
            end
            if (got.gesture_pending !== want.gesture_pending) begin
                $error("gesture_pending: expected %0d, actual %0d",
                       want.gesture_pending, got.gesture_pending);
                errors++;
            end
            if (got.timer_phase !== want.timer_phase) begin
                $error("timer_phase: expected %0d, actual %0d",
                       want.timer_phase, got.timer_phase);
                errors++;
            end
        endfunction

        function int outstanding();
            return predicted_outcomes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    gesture_scoreboard      sb;
    bit                     no_idle = 1'b0;
    int                     ready_wait = 0;
    int                     items_sent = 0;

    two_button_gesture_detector_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check each accepted result, then stall at random
    always @(posedge aclk) begin : result_sink
        int stall;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                sb.check_result(m_data);
                stall = no_idle ? 0 : $urandom_range(0, 6);
                if (stall != 0) begin
                    m_ready    <= 1'b0;
                    ready_wait <= stall;
                end
            end
        end else begin
            if (ready_wait <= 1) m_ready <= 1'b1;
            ready_wait <= ready_wait - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // Present one item after a random gap and hold it until accepted
    task automatic send(input logic [1:0] cmd, input logic b1, input logic b2);
        in_item_t it;
        int       gap;
        it.cmd              = cmd;
        it.button_one_level = b1;
        it.button_two_level = b2;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_accepted_item(it);
        items_sent++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Load all timing registers, plus one write to an unmapped index
    task automatic apply_settings(input logic [7:0] win, input logic [7:0] rep,
                                  input logic [7:0] hold, input logic [7:0] level,
                                  input logic [7:0] head);
        settle();
        write_reg(REG_GESTURE_WINDOW, win);
        write_reg(REG_REPEAT_WINDOW, rep);
        write_reg(REG_HOLD_CHECK, hold);
        write_reg(REG_LONG_THRESHOLD, level);
        write_reg(REG_HOLD_HEAD, head);
        write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, LAST_INDEX)), 8'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Tick with fixed pin levels until the detector goes idle or the cap is hit
    task automatic tick_until_idle(input logic b1, input logic b2, input int cap);
        int k;
        k = 0;
        while (sb.phase != PH_IDLE && k < cap) begin
            send(CMD_TICK, b1, b2);
            k++;
        end
    endtask

    // One or more quick presses, then let the window run out
    task automatic click_burst();
        int   n;
        int   btn;
        logic b1;
        logic b2;
        n   = $urandom_range(1, 4);
        btn = $urandom_range(0, 1);
        b1  = 1'b1;
        b2  = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) btn = 1 - btn;
            b1 = (btn == 0) ? 1'b0 : 1'b1;
            b2 = (btn == 1) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                b1 = 1'b0;
                b2 = 1'b0;
            end
            send(CMD_PRESS, b1, b2);
            repeat ($urandom_range(0, 2)) send(CMD_TICK, 1'b1, 1'b1);
        end
        // sometimes keep the last button down into hold checking
        if ($urandom_range(0, 3) == 0) tick_until_idle(b1, b2, 40);
        tick_until_idle(1'b1, 1'b1, 600);
    endtask

    // Press and keep holding, with an occasional extra press on the way
    task automatic long_hold();
        logic b1;
        logic b2;
        logic h1;
        logic h2;
        int   k;
        b1 = 1'b1;
        b2 = 1'b1;
        if ($urandom_range(0, 1) == 0) b1 = 1'b0;
        else b2 = 1'b0;
        h1 = b1;
        h2 = b2;
        if ($urandom_range(0, 3) == 0) begin
            h1 = 1'b0;
            h2 = 1'b0;
        end
        send(CMD_PRESS, b1, b2);
        k = 0;
        while (sb.phase != PH_IDLE && k < 300) begin
            if ($urandom_range(0, 24) == 0) send(CMD_PRESS, b1, b2);
            else send(CMD_TICK, h1, h2);
            k++;
        end
        tick_until_idle(1'b1, 1'b1, 600);
    endtask

    // Random sequence of gestures, reads and noise until the item budget is spent
    task automatic run_random(input int budget);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < budget) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 9);
            if (pick <= 3) begin
                click_burst();
            end else if (pick <= 5) begin
                long_hold();
            end else if (pick == 6) begin
                send(CMD_PRESS, 1'b0, 1'b0);
            end else if (pick == 7) begin
                send(CMD_READ, 1'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 1) == 0) send(CMD_READ, 1'($urandom), 1'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // Directed walk through one gesture of each kind, expects window 2, repeat 1,
    // hold check 1, threshold 3, head start 1
    task automatic directed_walk();
        // read with nothing pending, idle tick, unused command
        send(CMD_READ, 1'b1, 1'b1);
        send(CMD_TICK, 1'b1, 1'b1);
        send(CMD_UNUSED, 1'b0, 1'b0);
        // single on button one, read it
        send(CMD_PRESS, 1'b0, 1'b1);
        repeat (2) send(CMD_TICK, 1'b1, 1'b1);
        send(CMD_READ, 1'b1, 1'b1);
        // single on button two, left unread and overwritten by a double
        send(CMD_PRESS, 1'b1, 1'b0);
        repeat (2) send(CMD_TICK, 1'b1, 1'b1);
        send(CMD_PRESS, 1'b0, 1'b1);
        send(CMD_PRESS, 1'b0, 1'b1);
        send(CMD_TICK, 1'b1, 1'b1);
        send(CMD_READ, 1'b1, 1'b1);
        // both buttons pressed at once
        send(CMD_PRESS, 1'b0, 1'b0);
        send(CMD_READ, 1'b1, 1'b1);
        // one press on each button: pending with no gesture
        send(CMD_PRESS, 1'b0, 1'b1);
        send(CMD_PRESS, 1'b1, 1'b0);
        send(CMD_TICK, 1'b1, 1'b1);
        send(CMD_READ, 1'b1, 1'b1);
        // long press on button two
        send(CMD_PRESS, 1'b1, 1'b0);
        repeat (4) send(CMD_TICK, 1'b1, 1'b0);
        send(CMD_READ, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: saturate button one's count with a press storm
        repeat (260) send(CMD_PRESS, 1'b0, 1'b1);
        tick_until_idle(1'b1, 1'b1, 600);
        send(CMD_READ, 1'b1, 1'b1);
        run_random(100);

        // Short windows for the directed walk
        apply_settings(8'd2, 8'd1, 8'd1, 8'd3, 8'd1);
        directed_walk();
        run_random(120);

        // Minimum values
        apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
        run_random(120);

        // All zero: windows fire on the first tick, long press at once
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random(80);

        // Maximum values
        apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        run_random(260);

        // Random moderate settings
        repeat (2) begin
            apply_settings(8'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                           8'($urandom_range(1, 6)), 8'($urandom_range(1, 24)),
                           8'($urandom_range(0, 255)));
            run_random(100);
        end

        settle();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
